// ----- hdl/lpdf_pkg.sv -----
// Types shared by the length-prefixed deframer: input word and result word.
// No dependencies; used by the parser, the top level and the testbench.
package lpdf_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned TYPE_W = 32;
    localparam int unsigned LEN_W  = 32;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [TYPE_W-1:0] message_type;
        logic              first_of_message;
        logic              last_of_message;
        logic              empty_message;
    } t_out_word;

endpackage

// ----- hdl/lpdf_stream_if.sv -----
// Valid/ready stream channel carrying one word of type T.
// Depends on nothing; the payload type is set where the channel is declared.
interface lpdf_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/lpdf_parse.sv -----
// Header/payload parser state for the deframer: one byte per step.
// Depends on lpdf_pkg for the result word type.
module lpdf_parse #(
    parameter int unsigned FIELD_BYTES = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_step,
    input  logic [lpdf_pkg::BYTE_W-1:0]         i_byte,
    output logic                                o_emit,
    output lpdf_pkg::t_out_word                 o_result
);

    localparam int unsigned HDR_BYTES = 2 * FIELD_BYTES;
    localparam int unsigned IDX_W     = $clog2(HDR_BYTES);
    localparam int unsigned LANES     = lpdf_pkg::TYPE_W / lpdf_pkg::BYTE_W;

    logic [IDX_W-1:0]              r_idx,   n_idx;
    logic                          r_in_pl, n_in_pl;
    logic [lpdf_pkg::LEN_W-1:0]    r_len,   n_len;
    logic [lpdf_pkg::TYPE_W-1:0]   r_type,  n_type;
    logic [lpdf_pkg::LEN_W-1:0]    r_rem,   n_rem;
    logic                          r_first, n_first;

    always_comb begin
        logic [lpdf_pkg::TYPE_W-1:0] type_now;
        n_idx    = r_idx;
        n_in_pl  = r_in_pl;
        n_len    = r_len;
        n_type   = r_type;
        n_rem    = r_rem;
        n_first  = r_first;
        o_emit   = 1'b0;
        o_result = '0;
        type_now = r_type;
        if (!r_in_pl) begin
            for (int k = 0; k < LANES; k++) begin
                if (k < FIELD_BYTES && r_idx == IDX_W'(k))
                    n_len[k*lpdf_pkg::BYTE_W +: lpdf_pkg::BYTE_W] = i_byte;
                if (k < FIELD_BYTES && r_idx == IDX_W'(FIELD_BYTES + k))
                    type_now[k*lpdf_pkg::BYTE_W +: lpdf_pkg::BYTE_W] = i_byte;
            end
            n_type = type_now;
            if (r_idx != IDX_W'(HDR_BYTES - 1)) begin
                n_idx = r_idx + 1'b1;
            end else if (r_len == '0) begin
                o_emit                    = 1'b1;
                o_result.message_type     = type_now;
                o_result.first_of_message = 1'b1;
                o_result.last_of_message  = 1'b1;
                o_result.empty_message    = 1'b1;
                n_idx   = '0;
                n_in_pl = 1'b0;
                n_len   = '0;
                n_type  = '0;
                n_rem   = '0;
                n_first = 1'b1;
            end else begin
                n_idx   = '0;
                n_in_pl = 1'b1;
                n_rem   = r_len;
                n_first = 1'b1;
            end
        end else begin
            o_emit                    = 1'b1;
            o_result.payload_byte     = i_byte;
            o_result.message_type     = r_type;
            o_result.first_of_message = r_first;
            o_result.last_of_message  = (r_rem <= lpdf_pkg::LEN_W'(1));
            n_first = 1'b0;
            if (r_rem <= lpdf_pkg::LEN_W'(1)) begin
                n_idx   = '0;
                n_in_pl = 1'b0;
                n_len   = '0;
                n_type  = '0;
                n_rem   = '0;
                n_first = 1'b1;
            end else begin
                n_rem = r_rem - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_in_pl <= 1'b0;
            r_len   <= '0;
            r_type  <= '0;
            r_rem   <= '0;
            r_first <= 1'b1;
        end else if (i_step) begin
            r_idx   <= n_idx;
            r_in_pl <= n_in_pl;
            r_len   <= n_len;
            r_type  <= n_type;
            r_rem   <= n_rem;
            r_first <= n_first;
        end
    end

endmodule

// ----- hdl/length_prefixed_deframer_top.sv -----
// Length-prefixed deframer top level: input register, parser, result register.
// Depends on lpdf_pkg, lpdf_stream_if and lpdf_parse.
//
//   channel  direction  word        carries
//   i_in     sink       t_in_word   one raw stream byte
//   o_out    source     t_out_word  payload byte, type, first/last/empty marks
//
// One byte taken per cycle unless the output stalls; results are registered.
// Header bytes give no result; a zero-length message gives one empty result.
// Synchronous active-low reset returns the parser to the start of a header.
// A stalled result holds in the output register; the input register keeps
// taking bytes until it too is full and blocked.
module length_prefixed_deframer_top #(
    parameter int unsigned FIELD_BYTES = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lpdf_stream_if.sink           i_in,
    lpdf_stream_if.source         o_out
);

    logic                           r_stg_valid;
    logic [lpdf_pkg::BYTE_W-1:0]    r_stg_byte;
    logic                           r_out_valid;
    lpdf_pkg::t_out_word            r_out;

    logic                           can_load;
    logic                           stg_adv;
    logic                           emit;
    lpdf_pkg::t_out_word            result;

    assign can_load   = !r_out_valid || o_out.ready;
    assign stg_adv    = r_stg_valid && can_load;
    assign i_in.ready = !r_stg_valid || stg_adv;

    lpdf_parse #(
        .FIELD_BYTES (FIELD_BYTES)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (stg_adv),
        .i_byte   (r_stg_byte),
        .o_emit   (emit),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready)
                r_stg_valid <= 1'b1;
            else if (stg_adv)
                r_stg_valid <= 1'b0;
            if (stg_adv && emit)
                r_out_valid <= 1'b1;
            else if (o_out.ready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready)
            r_stg_byte <= i_in.data.data_byte;
        if (stg_adv && emit)
            r_out <= result;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

// ----- dv/tb_length_prefixed_deframer_top.sv -----
`timescale 1ns / 100ps
// Testbench for length_prefixed_deframer_top: sends framed byte streams and
// checks each result word against an in-bench deframer. Needs lpdf_pkg,
// lpdf_stream_if and the deframer RTL.
module tb_length_prefixed_deframer_top;

    localparam int unsigned FIELD_BYTES  = 4;
    localparam int unsigned HEADER_BYTES = 2 * FIELD_BYTES;
    localparam int          STALL_LIMIT  = 1000;
    localparam int          RANDOM_BYTES = 340;

    logic i_clk;
    logic i_rst_n;

    lpdf_stream_if #(.T(lpdf_pkg::t_in_word))  in_chan ();
    lpdf_stream_if #(.T(lpdf_pkg::t_out_word)) out_chan ();

    length_prefixed_deframer_top #(
        .FIELD_BYTES (FIELD_BYTES)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_chan.sink),
        .o_out   (out_chan.source)
    );

    int unsigned hdr_pos;
    bit          in_payload;
    logic [31:0] len_acc;
    logic [31:0] type_acc;
    logic [31:0] bytes_left;
    bit          first_pending;

    lpdf_pkg::t_out_word expected_results[$];
    int          error_count;
    int          bytes_sent;
    bit          no_idle;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic restart_header();
        hdr_pos       = 0;
        in_payload    = 1'b0;
        len_acc       = '0;
        type_acc      = '0;
        bytes_left    = '0;
        first_pending = 1'b1;
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        lpdf_pkg::t_out_word r;
        if (!in_payload) begin
            if (hdr_pos < FIELD_BYTES) begin
                if (hdr_pos < 4)
                    len_acc = len_acc | (32'(b) << (8 * hdr_pos));
            end else if (hdr_pos - FIELD_BYTES < 4) begin
                type_acc = type_acc | (32'(b) << (8 * (hdr_pos - FIELD_BYTES)));
            end
            if (hdr_pos + 1 < HEADER_BYTES) begin
                hdr_pos++;
            end else if (len_acc == 32'd0) begin
                r.payload_byte     = '0;
                r.message_type     = type_acc;
                r.first_of_message = 1'b1;
                r.last_of_message  = 1'b1;
                r.empty_message    = 1'b1;
                expected_results.insert(expected_results.size(), r);
                restart_header();
            end else begin
                hdr_pos       = 0;
                in_payload    = 1'b1;
                bytes_left    = len_acc;
                first_pending = 1'b1;
            end
        end else begin
            r.payload_byte     = b;
            r.message_type     = type_acc;
            r.first_of_message = first_pending;
            r.last_of_message  = (bytes_left <= 32'd1);
            r.empty_message    = 1'b0;
            expected_results.insert(expected_results.size(), r);
            first_pending = 1'b0;
            if (bytes_left <= 32'd1)
                restart_header();
            else
                bytes_left = bytes_left - 32'd1;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        lpdf_pkg::t_out_word exp_word;
        lpdf_pkg::t_out_word act_word;
        if (i_rst_n) begin
            if (out_chan.valid && out_chan.ready) begin
                act_word = out_chan.data;
                if (expected_results.size() == 0) begin
                    $error("unexpected result word: %0h", act_word);
                    error_count++;
                end else begin
                    exp_word = expected_results.pop_front();
                    check_field("payload_byte", 32'(exp_word.payload_byte),
                                32'(act_word.payload_byte));
                    check_field("message_type", exp_word.message_type,
                                act_word.message_type);
                    check_field("first_of_message", 32'(exp_word.first_of_message),
                                32'(act_word.first_of_message));
                    check_field("last_of_message", 32'(exp_word.last_of_message),
                                32'(act_word.last_of_message));
                    check_field("empty_message", 32'(exp_word.empty_message),
                                32'(act_word.empty_message));
                end
            end
            if (in_chan.valid && in_chan.ready)
                deframe_byte(in_chan.data.data_byte);
        end
    end

    always @(posedge i_clk) begin
        out_chan.ready <= no_idle || ($urandom_range(99) >= 35);
    end

    task automatic send_byte(input logic [7:0] b);
        while (!no_idle && $urandom_range(99) < 35) begin
            in_chan.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_chan.valid <= 1'b1;
        in_chan.data  <= lpdf_pkg::t_in_word'(b);
        @(posedge i_clk);
        while (!in_chan.ready)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [31:0] len, input logic [31:0] type_id);
        for (int i = 0; i < FIELD_BYTES; i++)
            send_byte((i < 4) ? 8'(len >> (8 * i)) : 8'($urandom_range(255)));
        for (int i = 0; i < FIELD_BYTES; i++)
            send_byte((i < 4) ? 8'(type_id >> (8 * i)) : 8'($urandom_range(255)));
    endtask

    task automatic send_random_message(input int unsigned len);
        send_header(len, $urandom());
        for (int unsigned i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)));
    endtask

    task automatic test_zero_length();
        send_header(32'd0, 32'hFFFF_FFFF);
    endtask

    task automatic test_short_payloads();
        send_header(32'd1, 32'h0000_0000);
        send_byte(8'hFF);
        send_header(32'd2, 32'h8000_0001);
        send_byte(8'h00);
        send_byte(8'hA5);
    endtask

    task automatic test_random_stream();
        int unsigned len;
        while (bytes_sent < RANDOM_BYTES) begin
            no_idle = (bytes_sent > 150) && (bytes_sent < 250);
            case ($urandom_range(9))
                0:       len = 0;
                1:       len = $urandom_range(13, 31);
                default: len = $urandom_range(1, 12);
            endcase
            send_random_message(len);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_long_length();
        send_header(32'hFFFF_FFFF, $urandom());
        for (int i = 0; i < 40; i++)
            send_byte(8'($urandom_range(255)));
    endtask

    initial begin
        int drain;
        restart_header();
        error_count   = 0;
        bytes_sent    = 0;
        no_idle       = 1'b0;
        i_rst_n       <= 1'b0;
        in_chan.valid <= 1'b0;
        in_chan.data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_length();
        test_short_payloads();
        test_random_stream();
        test_long_length();
        in_chan.valid <= 1'b0;

        drain = 0;
        while (expected_results.size() != 0 && drain < 20 * STALL_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (8) @(posedge i_clk);

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            if (expected_results.size() != 0)
                $error("%0d expected results never arrived", expected_results.size());
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
                quiet = 0;
            else
                quiet++;
        end
        $error("no word moved for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/lpdf_pkg.sv
hdl/lpdf_stream_if.sv
hdl/lpdf_parse.sv
hdl/length_prefixed_deframer_top.sv
dv/tb_length_prefixed_deframer_top.sv
